// ===== rtl/gar_pkg.sv =====
// Package for the gravity alignment rotation block.
// Holds the fixed port widths and the transaction structs; no dependencies.
package gar_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    typedef struct packed {
        logic signed [IN_W-1:0] gravity_x;
        logic signed [IN_W-1:0] gravity_y;
        logic signed [IN_W-1:0] gravity_z;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] rot_r0c0;
        logic signed [OUT_W-1:0] rot_r0c1;
        logic signed [OUT_W-1:0] rot_r0c2;
        logic signed [OUT_W-1:0] rot_r1c0;
        logic signed [OUT_W-1:0] rot_r1c1;
        logic signed [OUT_W-1:0] rot_r1c2;
        logic signed [OUT_W-1:0] rot_r2c0;
        logic signed [OUT_W-1:0] rot_r2c1;
        logic signed [OUT_W-1:0] rot_r2c2;
        logic                    degenerate;
    } result_t;

endpackage

// ===== rtl/gravity_align_rotation_matrix.sv =====
// Gravity alignment rotation matrix, Rodrigues form, fully pipelined.
// Takes one transaction per cycle.
// The square root takes IN_W + FRAC_BITS stages, the two divisions FRAC_BITS + 2 and + 3.
// busy is always low and done strobes for one cycle per transaction.
// Reset clears only the valid bits; depends on gar_pkg, gar_sqrt and gar_div.
module gravity_align_rotation_matrix
    import gar_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  sample_t sample,
    output logic    done,
    output result_t result
);

    localparam int W    = IN_W;
    localparam int F    = FRAC_BITS;
    localparam int LW   = W + F;
    localparam int NW1  = W + 2 * F + 1;
    localparam int QW1  = F + 2;
    localparam int NW2  = 2 * W + F + 3;
    localparam int QW2  = F + 3;
    localparam int NSW  = F + 2;
    localparam int EW   = (F + 5 > OUT_W) ? F + 5 : OUT_W;
    localparam int SB1W = 11 * W + 6;
    localparam int SB2W = 8 * W + 6;
    localparam int SB3W = 3 * NSW + 4;
    localparam logic [QW1-1:0]      ONE_Q = QW1'(1) << F;
    localparam logic signed [EW-1:0] ONE_E = EW'(1) << F;

    // Input register.
    logic    s0_valid_reg;
    sample_t s0_g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s0_g_reg <= sample;
    end

    assign busy = 1'b0;

    // Stage 1: magnitudes and squares.
    logic           s1_valid_reg;
    logic [W-1:0]   s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic           s1_sx_reg, s1_sy_reg, s1_sz_reg;
    logic [2*W-1:0] s1_sqx_reg, s1_sqy_reg, s1_sqz_reg, s1_mxy_reg;
    logic [W-1:0]   s1_ax_next, s1_ay_next, s1_az_next;

    always_comb
    begin
        s1_ax_next = s0_g_reg.gravity_x[W-1] ? W'(-s0_g_reg.gravity_x) : W'(s0_g_reg.gravity_x);
        s1_ay_next = s0_g_reg.gravity_y[W-1] ? W'(-s0_g_reg.gravity_y) : W'(s0_g_reg.gravity_y);
        s1_az_next = s0_g_reg.gravity_z[W-1] ? W'(-s0_g_reg.gravity_z) : W'(s0_g_reg.gravity_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_ax_reg  <= s1_ax_next;
        s1_ay_reg  <= s1_ay_next;
        s1_az_reg  <= s1_az_next;
        s1_sx_reg  <= s0_g_reg.gravity_x[W-1];
        s1_sy_reg  <= s0_g_reg.gravity_y[W-1];
        s1_sz_reg  <= s0_g_reg.gravity_z[W-1];
        s1_sqx_reg <= s1_ax_next * s1_ax_next;
        s1_sqy_reg <= s1_ay_next * s1_ay_next;
        s1_sqz_reg <= s1_az_next * s1_az_next;
        s1_mxy_reg <= s1_ax_next * s1_ay_next;
    end

    // Stage 2: sums and the special-case flags.
    logic            s2_valid_reg;
    logic [2*W-1:0]  s2_s_reg;
    logic [SB1W-1:0] s2_sb_reg;
    logic [2*W-1:0]  s2_p;
    logic            s2_zxy, s2_gzpos, s2_deg;

    always_comb
    begin
        s2_p     = s1_sqx_reg + s1_sqy_reg;
        s2_zxy   = (s1_ax_reg == '0) && (s1_ay_reg == '0);
        s2_gzpos = !s1_sz_reg && (s1_az_reg != '0);
        s2_deg   = s2_zxy && !s1_sz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_s_reg  <= s2_p + s1_sqz_reg;
        s2_sb_reg <= {s1_ax_reg, s1_ay_reg, s1_az_reg, s1_sx_reg, s1_sy_reg, s1_sz_reg,
                      s1_sqx_reg, s1_sqy_reg, s1_mxy_reg, s2_p, s2_zxy, s2_gzpos, s2_deg};
    end

    // Square root: |g| with F fraction bits.
    logic            sq_valid;
    logic [LW-1:0]   sq_root;
    logic [SB1W-1:0] sq_sb;

    gar_sqrt #(
        .SW   (2 * W),
        .FRAC (F),
        .SBW  (SB1W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .radicand  (s2_s_reg),
        .sb_in     (s2_sb_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .sb_out    (sq_sb)
    );

    // Stage 3: rounded numerators for the normalized vector.
    logic [W-1:0]   q_ax, q_ay, q_az;
    logic           q_sx, q_sy, q_sz;
    logic [2*W-1:0] q_sqx, q_sqy, q_mxy, q_p;
    logic           q_zxy, q_gzpos, q_deg;

    always_comb
    begin
        {q_ax, q_ay, q_az, q_sx, q_sy, q_sz, q_sqx, q_sqy, q_mxy, q_p,
         q_zxy, q_gzpos, q_deg} = sq_sb;
    end

    logic                     s3_valid_reg;
    logic [2:0][NW1-1:0]      s3_num_reg;
    logic [LW-1:0]            s3_lq_reg;
    logic [SB2W-1:0]          s3_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        s3_num_reg[0] <= (NW1'(q_ax) << (2 * F)) + NW1'(sq_root >> 1);
        s3_num_reg[1] <= (NW1'(q_ay) << (2 * F)) + NW1'(sq_root >> 1);
        s3_num_reg[2] <= (NW1'(q_az) << (2 * F)) + NW1'(sq_root >> 1);
        s3_lq_reg     <= sq_root;
        s3_sb_reg     <= {q_sx, q_sy, q_sz, q_sqx, q_sqy, q_mxy, q_p, q_zxy, q_gzpos, q_deg};
    end

    logic                 d1_valid;
    logic [2:0][QW1-1:0]  d1_quo;
    logic [SB2W-1:0]      d1_sb;

    gar_div #(
        .NW    (NW1),
        .DW    (LW),
        .QW    (QW1),
        .LANES (3),
        .SBW   (SB2W)
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .num       (s3_num_reg),
        .den       (s3_lq_reg),
        .sb_in     (s3_sb_reg),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .sb_out    (d1_sb)
    );

    // Stage 4: saturate, apply signs, form b = 1 + nz.
    logic           e_sx, e_sy, e_sz;
    logic [2*W-1:0] e_sqx, e_sqy, e_mxy, e_p;
    logic           e_zxy, e_gzpos, e_deg;
    logic [QW1-1:0] e_qx, e_qy, e_qz;

    always_comb
    begin
        {e_sx, e_sy, e_sz, e_sqx, e_sqy, e_mxy, e_p, e_zxy, e_gzpos, e_deg} = d1_sb;
        e_qx = (d1_quo[0] > ONE_Q) ? ONE_Q : d1_quo[0];
        e_qy = (d1_quo[1] > ONE_Q) ? ONE_Q : d1_quo[1];
        e_qz = (d1_quo[2] > ONE_Q) ? ONE_Q : d1_quo[2];
    end

    logic                  s4_valid_reg;
    logic signed [NSW-1:0] s4_nx_reg, s4_ny_reg, s4_nz_reg;
    logic [QW1-1:0]        s4_b_reg;
    logic [2*W-1:0]        s4_sqx_reg, s4_sqy_reg, s4_mxy_reg, s4_p_reg;
    logic                  s4_sxy_reg, s4_zxy_reg, s4_gzpos_reg, s4_deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        s4_nx_reg    <= e_sx ? -signed'(e_qx) : signed'(e_qx);
        s4_ny_reg    <= e_sy ? -signed'(e_qy) : signed'(e_qy);
        s4_nz_reg    <= e_sz ? -signed'(e_qz) : signed'(e_qz);
        s4_b_reg     <= e_sz ? (ONE_Q - e_qz) : (ONE_Q + e_qz);
        s4_sqx_reg   <= e_sqx;
        s4_sqy_reg   <= e_sqy;
        s4_mxy_reg   <= e_mxy;
        s4_p_reg     <= e_p;
        s4_sxy_reg   <= e_sx ^ e_sy;
        s4_zxy_reg   <= e_zxy;
        s4_gzpos_reg <= e_gzpos;
        s4_deg_reg   <= e_deg;
    end

    // Stage 5: numerators of the outer-product terms.
    logic                 s5_valid_reg;
    logic [2:0][NW2-1:0]  s5_num_reg;
    logic [2*W-1:0]       s5_p_reg;
    logic [SB3W-1:0]      s5_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_num_reg[0] <= NW2'(s4_sqx_reg) * NW2'(s4_b_reg) + NW2'(s4_p_reg >> 1);
        s5_num_reg[1] <= NW2'(s4_mxy_reg) * NW2'(s4_b_reg) + NW2'(s4_p_reg >> 1);
        s5_num_reg[2] <= NW2'(s4_sqy_reg) * NW2'(s4_b_reg) + NW2'(s4_p_reg >> 1);
        s5_p_reg      <= s4_p_reg;
        s5_sb_reg     <= {s4_nx_reg, s4_ny_reg, s4_nz_reg, s4_sxy_reg,
                          s4_zxy_reg, s4_gzpos_reg, s4_deg_reg};
    end

    logic                 d2_valid;
    logic [2:0][QW2-1:0]  d2_quo;
    logic [SB3W-1:0]      d2_sb;

    gar_div #(
        .NW    (NW2),
        .DW    (2 * W),
        .QW    (QW2),
        .LANES (3),
        .SBW   (SB3W)
    ) u_div_outer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .num       (s5_num_reg),
        .den       (s5_p_reg),
        .sb_in     (s5_sb_reg),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .sb_out    (d2_sb)
    );

    // Output stage: assemble the matrix, then override the special cases.
    logic signed [NSW-1:0] f_nx, f_ny, f_nz;
    logic                  f_sxy, f_zxy, f_gzpos, f_deg;
    logic signed [EW-1:0]  f_txx, f_txy, f_tyy, f_nxe, f_nye, f_nze;
    logic signed [EW-1:0]  r [9];
    result_t               result_next;
    result_t               result_reg;
    logic                  done_reg;

    always_comb
    begin
        {f_nx, f_ny, f_nz, f_sxy, f_zxy, f_gzpos, f_deg} = d2_sb;
        f_txx = EW'(d2_quo[0]);
        f_txy = EW'(d2_quo[1]);
        f_tyy = EW'(d2_quo[2]);
        f_nxe = EW'(f_nx);
        f_nye = EW'(f_ny);
        f_nze = EW'(f_nz);
        r[0] = ONE_E - f_txx;
        r[1] = f_sxy ? f_txy : -f_txy;
        r[2] = f_nxe;
        r[3] = r[1];
        r[4] = ONE_E - f_tyy;
        r[5] = f_nye;
        r[6] = -f_nxe;
        r[7] = -f_nye;
        r[8] = -f_nze;
        if (f_zxy)
        begin
            for (int i = 0; i < 9; i++)
                r[i] = '0;
            r[0] = ONE_E;
            r[4] = f_gzpos ? -ONE_E : ONE_E;
            r[8] = f_gzpos ? -ONE_E : ONE_E;
        end
        result_next.rot_r0c0   = r[0][OUT_W-1:0];
        result_next.rot_r0c1   = r[1][OUT_W-1:0];
        result_next.rot_r0c2   = r[2][OUT_W-1:0];
        result_next.rot_r1c0   = r[3][OUT_W-1:0];
        result_next.rot_r1c1   = r[4][OUT_W-1:0];
        result_next.rot_r1c2   = r[5][OUT_W-1:0];
        result_next.rot_r2c0   = r[6][OUT_W-1:0];
        result_next.rot_r2c1   = r[7][OUT_W-1:0];
        result_next.rot_r2c2   = r[8][OUT_W-1:0];
        result_next.degenerate = f_deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/gar_sqrt.sv =====
// Pipelined integer square root of radicand * 2^(2*FRAC), one root bit per stage.
// Carries a sideband vector alongside; uses gar_pkg.
module gar_sqrt
    import gar_pkg::*;
#(
    parameter int SW   = 32,
    parameter int FRAC = 14,
    parameter int SBW  = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [SW-1:0]            radicand,
    input  logic [SBW-1:0]           sb_in,
    output logic                     out_valid,
    output logic [SW/2+FRAC-1:0]     root,
    output logic [SBW-1:0]           sb_out
);

    localparam int LW = SW / 2 + FRAC;
    localparam int XW = 2 * LW;
    localparam int RW = LW + 2;

    logic [RW-1:0]  rem_reg   [LW];
    logic [RW-1:0]  rem_next  [LW];
    logic [LW-1:0]  root_reg  [LW];
    logic [LW-1:0]  root_next [LW];
    logic [XW-1:0]  x_reg     [LW];
    logic [XW-1:0]  x_next    [LW];
    logic [SBW-1:0] sb_reg    [LW];
    logic [SBW-1:0] sb_next   [LW];
    logic           valid_reg [LW];
    logic           valid_next[LW];

    always_comb
    begin
        logic [RW-1:0]  rem_cur;
        logic [LW-1:0]  root_cur;
        logic [XW-1:0]  x_cur;
        logic [RW+1:0]  rem4;
        logic [RW+1:0]  trial;
        logic [RW+1:0]  diff;
        for (int s = 0; s < LW; s++)
        begin
            if (s == 0)
            begin
                rem_cur       = '0;
                root_cur      = '0;
                x_cur         = {radicand, {(2*FRAC){1'b0}}};
                sb_next[s]    = sb_in;
                valid_next[s] = in_valid;
            end
            else
            begin
                rem_cur       = rem_reg[s-1];
                root_cur      = root_reg[s-1];
                x_cur         = x_reg[s-1];
                sb_next[s]    = sb_reg[s-1];
                valid_next[s] = valid_reg[s-1];
            end
            rem4  = {rem_cur, x_cur[XW-1 -: 2]};
            trial = {2'b00, root_cur, 2'b01};
            diff  = rem4 - trial;
            if (rem4 >= trial)
            begin
                rem_next[s]  = diff[RW-1:0];
                root_next[s] = {root_cur[LW-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem4[RW-1:0];
                root_next[s] = {root_cur[LW-2:0], 1'b0};
            end
            x_next[s] = {x_cur[XW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LW; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < LW; s++)
                valid_reg[s] <= valid_next[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < LW; s++)
        begin
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
            x_reg[s]    <= x_next[s];
            sb_reg[s]   <= sb_next[s];
        end
    end

    assign out_valid = valid_reg[LW-1];
    assign root      = root_reg[LW-1];
    assign sb_out    = sb_reg[LW-1];

endmodule

// ===== rtl/gar_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing
// one divisor and a sideband vector. Uses gar_pkg.
module gar_div
    import gar_pkg::*;
#(
    parameter int NW    = 16,
    parameter int DW    = 8,
    parameter int QW    = 8,
    parameter int LANES = 1,
    parameter int SBW   = 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [LANES-1:0][NW-1:0]     num,
    input  logic [DW-1:0]                den,
    input  logic [SBW-1:0]               sb_in,
    output logic                         out_valid,
    output logic [LANES-1:0][QW-1:0]     quo,
    output logic [SBW-1:0]               sb_out
);

    logic [LANES-1:0][DW-1:0] rem_reg   [QW];
    logic [LANES-1:0][DW-1:0] rem_next  [QW];
    logic [LANES-1:0][QW-1:0] qn_reg    [QW];
    logic [LANES-1:0][QW-1:0] qn_next   [QW];
    logic [DW-1:0]            den_reg   [QW];
    logic [DW-1:0]            den_next  [QW];
    logic [SBW-1:0]           sb_reg    [QW];
    logic [SBW-1:0]           sb_next   [QW];
    logic                     valid_reg [QW];
    logic                     valid_next[QW];

    always_comb
    begin
        logic [LANES-1:0][DW-1:0] rem_cur;
        logic [LANES-1:0][QW-1:0] qn_cur;
        logic [DW:0]              rem2;
        logic [DW:0]              diff;
        for (int s = 0; s < QW; s++)
        begin
            if (s == 0)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_cur[l] = DW'(num[l][NW-1:QW]);
                    qn_cur[l]  = num[l][QW-1:0];
                end
                den_next[s]   = den;
                sb_next[s]    = sb_in;
                valid_next[s] = in_valid;
            end
            else
            begin
                rem_cur       = rem_reg[s-1];
                qn_cur        = qn_reg[s-1];
                den_next[s]   = den_reg[s-1];
                sb_next[s]    = sb_reg[s-1];
                valid_next[s] = valid_reg[s-1];
            end
            for (int l = 0; l < LANES; l++)
            begin
                rem2 = {rem_cur[l], qn_cur[l][QW-1]};
                diff = rem2 - {1'b0, den_next[s]};
                if (rem2 >= {1'b0, den_next[s]})
                begin
                    rem_next[s][l] = diff[DW-1:0];
                    qn_next[s][l]  = {qn_cur[l][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][l] = rem2[DW-1:0];
                    qn_next[s][l]  = {qn_cur[l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QW; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < QW; s++)
                valid_reg[s] <= valid_next[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QW; s++)
        begin
            rem_reg[s] <= rem_next[s];
            qn_reg[s]  <= qn_next[s];
            den_reg[s] <= den_next[s];
            sb_reg[s]  <= sb_next[s];
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = qn_reg[QW-1];
    assign sb_out    = sb_reg[QW-1];

endmodule

// ===== rtl/gar_checker.sv =====
// Port-level checker for gravity_align_rotation_matrix, bound to the top level.
// Depends on gar_pkg.
module gar_checker
    import gar_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input sample_t sample,
    input logic    done,
    input result_t result
);

    localparam int LAT = 3 * FRAC_BITS + 12 + IN_W;
    localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << FRAC_BITS;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the pipeline never stalls");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("transaction did not complete after the pipeline latency");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result strobe without a matching transaction");

    a_degenerate_shape: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate |-> result.rot_r0c0 == ONE && result.rot_r0c1 == '0
            && result.rot_r0c2 == '0 && result.rot_r1c0 == '0 && result.rot_r2c1 == '0)
        else $error("degenerate result is not diagonal");

endmodule

bind gravity_align_rotation_matrix gar_checker #(.FRAC_BITS(FRAC_BITS)) u_gar_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for gravity_align_rotation_matrix.
// Drives gravity samples, predicts each rotation matrix in fixed point and compares results.
// Depends on gar_pkg and the block's RTL.
module tb;
    import gar_pkg::*;

    localparam int FRAC    = 14;
    localparam int LATENCY = 3 * FRAC + 28;
    localparam int N_RAND  = 1400;
    localparam longint ONE = 64'sd1 << FRAC;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    sample_t sample;
    logic    done;
    result_t result;

    result_t matrix_q[$];
    int      errors;
    longint  cycles;
    bit      finishing;

    gravity_align_rotation_matrix #(.FRAC_BITS(FRAC)) i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .sample (sample),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint clip_one(longint v);
        if (v > ONE)
            return ONE;
        if (v < -ONE)
            return -ONE;
        return v;
    endfunction

    function automatic result_t rotation_of(sample_t s);
        result_t r;
        longint gx, gy, gz, p, sq, lq, nx, ny, nz, b, txx, txy, tyy;
        gx = s.gravity_x;
        gy = s.gravity_y;
        gz = s.gravity_z;
        r = '0;
        if (gx == 0 && gy == 0)
        begin
            r.rot_r0c0 = OUT_W'(ONE);
            r.rot_r1c1 = OUT_W'(ONE);
            r.rot_r2c2 = OUT_W'(ONE);
            if (gz >= 0)
            begin
                r.degenerate = 1'b1;
                if (gz > 0)
                begin
                    r.rot_r1c1 = OUT_W'(-ONE);
                    r.rot_r2c2 = OUT_W'(-ONE);
                end
            end
        end
        else
        begin
            p = gx * gx + gy * gy;
            sq = p + gz * gz;
            lq = longint'(int_sqrt(longint'(sq) << (2 * FRAC)));
            nx = clip_one(round_div(gx <<< (2 * FRAC), lq));
            ny = clip_one(round_div(gy <<< (2 * FRAC), lq));
            nz = clip_one(round_div(gz <<< (2 * FRAC), lq));
            b = ONE + nz;
            txx = round_div(gx * gx * b, p);
            txy = round_div(gx * gy * b, p);
            tyy = round_div(gy * gy * b, p);
            r.rot_r0c0 = OUT_W'(ONE - txx);
            r.rot_r0c1 = OUT_W'(-txy);
            r.rot_r0c2 = OUT_W'(nx);
            r.rot_r1c0 = OUT_W'(-txy);
            r.rot_r1c1 = OUT_W'(ONE - tyy);
            r.rot_r1c2 = OUT_W'(ny);
            r.rot_r2c0 = OUT_W'(-nx);
            r.rot_r2c1 = OUT_W'(-ny);
            r.rot_r2c2 = OUT_W'(-nz);
        end
        return r;
    endfunction

    function automatic result_t diag_matrix(longint d0, longint d1, longint d2, bit flag);
        result_t r;
        r = '0;
        r.rot_r0c0 = OUT_W'(d0);
        r.rot_r1c1 = OUT_W'(d1);
        r.rot_r2c2 = OUT_W'(d2);
        r.degenerate = flag;
        return r;
    endfunction

    // Results cannot be held off, so every strobe is checked as it arrives.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (matrix_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                result_t want;
                want = matrix_q.pop_front();
                if (result !== want)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 200000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_sample(sample_t s, result_t want, bit typed, bit quiet);
        if (!quiet && $urandom_range(99) < 3)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy);
        matrix_q.push_back(typed ? want : rotation_of(s));
    endtask

    typedef struct {
        sample_t s;
        bit      typed;
        result_t want;
    } row_t;

    initial
    begin
        row_t rows[$];
        sample_t s;
        int k;
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, diag_matrix(ONE, ONE, ONE, 1'b1)});
        rows.push_back('{'{16'sd0, 16'sd0, -16'sd1}, 1'b1, diag_matrix(ONE, ONE, ONE, 1'b0)});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sh8000}, 1'b1,
                         diag_matrix(ONE, ONE, ONE, 1'b0)});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd1}, 1'b1, diag_matrix(ONE, -ONE, -ONE, 1'b1)});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd32767}, 1'b1,
                         diag_matrix(ONE, -ONE, -ONE, 1'b1)});
        rows.push_back('{'{16'sd1, 16'sd0, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd0, -16'sd1, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0});
        rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0});
        rows.push_back('{'{16'sh8000, 16'sd32767, 16'sh8000}, 1'b0, '0});
        rows.push_back('{'{16'sd1, 16'sd0, 16'sd32767}, 1'b0, '0});
        rows.push_back('{'{16'sd1, 16'sd1, 16'sh8000}, 1'b0, '0});
        rows.push_back('{'{-16'sd1, 16'sd1, 16'sd32767}, 1'b0, '0});
        rows.push_back('{'{16'sd3, 16'sd4, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, '0});
        rows.push_back('{'{-16'sd5461, 16'sd100, -16'sd9000}, 1'b0, '0});
        foreach (rows[i])
            send_sample(rows[i].s, rows[i].want, rows[i].typed, 1'b0);

        for (k = 0; k < N_RAND; k++)
        begin
            case ($urandom_range(9))
                0: s = '{16'sd0, 16'sd0, 16'($urandom)};
                1: s = '{16'($urandom_range(3) - 1), 16'($urandom_range(3) - 1),
                         16'($urandom)};
                2: s = '{16'($urandom_range(63) - 32), 16'($urandom_range(63) - 32),
                         16'($urandom_range(63) - 32)};
                default: s = '{16'($urandom), 16'($urandom), 16'($urandom)};
            endcase
            send_sample(s, '0, 1'b0, k >= 400 && k < 700);
        end
        start <= 1'b0;

        while (matrix_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
